// ===== hdl/tksil_pkg.sv =====
// ----------------------------------------------------------------------------
// tksil_pkg
// Shared types and codes for the top-k sorted insertion list.
// ----------------------------------------------------------------------------
`default_nettype none

package tksil_pkg;

    localparam int ID_W    = 12;
    localparam int SCORE_W = 32;
    localparam int RANK_W  = 6;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 6;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } slot_t;

    typedef struct packed {
        logic                      insert;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } ins_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/tksil_cell.sv =====
// ----------------------------------------------------------------------------
// tksil_cell
// One slot of the sorted list: compares the new score against its own entry,
// and on insert either keeps its entry, takes the new pair or takes the entry
// of the slot above it.
// ----------------------------------------------------------------------------
`default_nettype none

module tksil_cell
    import tksil_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int FILL_W   = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ins_cmd_t          cmd,
    input  wire logic [FILL_W-1:0] fill_count,
    input  wire slot_t             prev_slot,
    input  wire logic              prev_take,
    input  wire logic [RANK_W-1:0] rank,
    output slot_t                  slot,
    output logic                   take,
    output logic [ID_W-1:0]        rd_id
);

    localparam logic [FILL_W-1:0] IDX_V  = FILL_W'(CELL_IDX);
    localparam bit                HIT_OK = (CELL_IDX < (1 << RANK_W));
    localparam logic [RANK_W-1:0] IDX_R  = RANK_W'(CELL_IDX % (1 << RANK_W));

    slot_t slot_reg;
    slot_t slot_next;

    assign take = (IDX_V >= fill_count) || ($signed(cmd.score) > $signed(slot_reg.score));

    always_comb begin
        slot_next = slot_reg;
        if (cmd.insert) begin
            if (prev_take && (IDX_V <= fill_count)) begin
                slot_next = prev_slot;
            end else if (take && !prev_take) begin
                slot_next.id    = cmd.id;
                slot_next.score = cmd.score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= slot_next;
        end
    end

    assign slot  = slot_reg;
    assign rd_id = (HIT_OK && (rank == IDX_R)) ? slot_reg.id : '0;

endmodule

`default_nettype wire

// ===== hdl/top_k_sorted_insert_list.sv =====
// The result is registered and appears on the master side in the cycle after the input transfer.
// Throughput: one item per cycle while m_tready does not stall the result; every cell compares and shifts in parallel.
// The result register is freed in the same cycle it is taken, so no bubbles.
// Reset (aresetn low, synchronous): list empty, all slots zero, no result.
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list
// Keeps the best CAPACITY (id, score) pairs in descending score order in a
// row of compare-and-shift cells; supports insert, clear, count and read.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_sorted_insert_list
    import tksil_pkg::*;
#(
    parameter int CAPACITY = 40
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // mode[1:0], entry_id[13:2], score[45:14], rank[51:46], zero[55:52]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // held_count[5:0], read_id[17:6], zero[23:18]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam logic [FILL_W-1:0] CAP_V = FILL_W'(CAPACITY);

    logic [MODE_W-1:0]  in_mode;
    logic [ID_W-1:0]    in_id;
    logic [SCORE_W-1:0] in_score;
    logic [RANK_W-1:0]  in_rank;
    logic               accept;

    logic [FILL_W-1:0]  fill_count_reg;
    logic [FILL_W-1:0]  fill_count_next;
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    ins_cmd_t          cmd;
    slot_t             slots [CAPACITY];
    logic              takes [CAPACITY];
    logic [ID_W-1:0]   rd_ids [CAPACITY];
    logic [ID_W-1:0]   rd_any;
    logic [ID_W-1:0]   read_id;
    logic [FILL_W+COUNT_W-1:0] fill_ext;

    assign in_mode  = s_tdata[1:0];
    assign in_id    = s_tdata[13:2];
    assign in_score = s_tdata[45:14];
    assign in_rank  = s_tdata[51:46];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cmd.insert = accept && (in_mode == MODE_INSERT);
    assign cmd.id     = in_id;
    assign cmd.score  = $signed(in_score);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            tksil_cell #(
                .CELL_IDX (i),
                .FILL_W   (FILL_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .fill_count (fill_count_reg),
                .prev_slot  ('0),
                .prev_take  (1'b0),
                .rank       (in_rank),
                .slot       (slots[i]),
                .take       (takes[i]),
                .rd_id      (rd_ids[i])
            );
        end else begin : g_body
            tksil_cell #(
                .CELL_IDX (i),
                .FILL_W   (FILL_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .fill_count (fill_count_reg),
                .prev_slot  (slots[i-1]),
                .prev_take  (takes[i-1]),
                .rank       (in_rank),
                .slot       (slots[i]),
                .take       (takes[i]),
                .rd_id      (rd_ids[i])
            );
        end
    end

    always_comb begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_any = rd_any | rd_ids[i];
        end
    end

    always_comb begin
        fill_count_next = fill_count_reg;
        read_id         = '0;
        case (in_mode)
            MODE_INSERT: begin
                if (fill_count_reg < CAP_V) begin
                    fill_count_next = fill_count_reg + FILL_W'(1);
                end
            end
            MODE_CLEAR: begin
                fill_count_next = '0;
            end
            MODE_COUNT: begin
                fill_count_next = fill_count_reg;
            end
            MODE_READ: begin
                read_id = rd_any;
            end
            default: begin
                fill_count_next = fill_count_reg;
            end
        endcase
    end

    assign fill_ext     = {{COUNT_W{1'b0}}, fill_count_next};
    assign m_tdata_next = {{(OUT_DATA_W - COUNT_W - ID_W){1'b0}}, read_id,
                           fill_ext[COUNT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                fill_count_reg <= fill_count_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CAP_V)
        else $error("fill count beyond capacity");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_count_reg >= FILL_W'(2)) |-> ($signed(slots[0].score) >= $signed(slots[1].score)))
        else $error("first two slots out of order");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("transfer accepted without a result");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_mode == MODE_CLEAR)) |=> (fill_count_reg == '0))
        else $error("clear left entries held");

endmodule

`default_nettype wire
